### rtl/lpet_pkg.sv
package lpet_pkg;

  typedef logic [1:0]  action_t;
  typedef logic [15:0] obj_id_t;
  typedef logic [39:0] obj_size_t;
  typedef logic [43:0] bytes_t;
  typedef logic [1:0]  status_t;

  localparam action_t ACT_REG   = 2'd0;
  localparam action_t ACT_PIN   = 2'd1;
  localparam action_t ACT_LIST  = 2'd2;
  localparam action_t ACT_QUERY = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UPDATED = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_NONE    = 2'd3;

  localparam int     MAX_RESULTS = 16;
  localparam bytes_t LIMIT_RESET = 44'd8589934592;
  localparam bytes_t BYTES_MAX   = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_UPD  = 6'b000100,
    S_WRD  = 6'b001000,
    S_WDT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

### rtl/lpet_if.sv
interface lpet_in_if;
  logic                valid;
  logic                ready;
  lpet_pkg::action_t   action;
  lpet_pkg::obj_id_t   object_id;
  lpet_pkg::obj_size_t object_size;
  logic                pin_value;
  lpet_pkg::bytes_t    needed_bytes;

  modport source (output valid, action, object_id, object_size, pin_value, needed_bytes,
                  input ready);
  modport sink   (input valid, action, object_id, object_size, pin_value, needed_bytes,
                  output ready);
endinterface

interface lpet_out_if;
  logic              valid;
  logic              ready;
  lpet_pkg::status_t status;
  lpet_pkg::obj_id_t victim_id;
  lpet_pkg::bytes_t  free_bytes;
  logic              last;

  modport source (output valid, status, victim_id, free_bytes, last, input ready);
  modport sink   (input valid, status, victim_id, free_bytes, last, output ready);
endinterface

### rtl/lru_pinned_eviction_table.sv
// Register / pin: id search (S_SCAN), table update (S_UPD), then the result (S_FIN)
//   (id search walks the slot RAM one entry a cycle; no entry is read on an empty table).
//   The next item is taken the cycle after the result is loaded.
// Candidate list: S_WRD+S_WDT per id, S_WRD per pinned rank skipped, up to 16 results.
// Available query: result loaded in S_FIN once the output is free, next item taken the cycle after.
//   One item in flight; next item taken once the last result sits in the output register.
// Reset (rst_n, synchronous): table empty, pins clear, usage zero, limit 8 GiB.
module lru_pinned_eviction_table #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  lpet_in_if.sink           in_ch,
  lpet_out_if.source        out_ch,
  input  logic              cfg_we,
  input  lpet_pkg::bytes_t  cfg_wdata
);
  import lpet_pkg::*;

  localparam int RW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = $clog2(MAX_RESULTS + 1);
  localparam int DW = 56;

  state_t state_r, state_nxt;

  // latched item
  action_t   act_r;
  obj_id_t   id_r;
  obj_size_t size_r;
  logic      pin_r;
  bytes_t    need_r;

  // id search pipeline: address stage then compare stage
  logic [CW-1:0] cnt_r;
  logic          cmp_v_r;
  logic [RW-1:0] cmp_idx_r;
  logic          hit_r;
  logic [RW-1:0] hit_idx_r;

  // table state: slots fill in order, so valid means index < count
  logic [CW-1:0] count_r;
  logic [RW-1:0] rank_r [ENTRIES];
  logic          pinned_r [ENTRIES];
  bytes_t        usage_r;
  bytes_t        limit_r;

  // candidate walk, oldest rank first
  logic [RW-1:0] r_r;
  logic          more_r;
  logic [KW-1:0] k_r;
  bytes_t        freed_r;

  // pending result; during the walk vid_r holds the candidate not yet sent
  status_t st_r;
  obj_id_t vid_r;

  logic    out_valid_r;
  status_t out_status_r;
  obj_id_t out_vid_r;
  bytes_t  out_free_r;
  logic    out_last_r;

  // slot RAM: {id, size}
  logic          ram_we, ram_re;
  logic [RW-1:0] ram_wa, ram_ra;
  logic [DW-1:0] ram_wd, ram_q;
  obj_id_t       q_id;
  obj_size_t     q_size;

  logic          scan_issue;
  logic          out_free;
  logic          out_load;
  logic          walk_done;
  logic [RW-1:0] walk_s;
  logic          full;
  logic [44:0]   usage_sum;
  bytes_t        avail;

  assign q_id   = ram_q[DW-1:40];
  assign q_size = ram_q[39:0];

  assign scan_issue = cnt_r < count_r;
  assign out_free   = !out_valid_r || out_ch.ready;
  // output register takes a new transfer this edge
  assign out_load   = ((state_r == S_WDT) && (k_r != '0) && out_free) ||
                      ((state_r == S_FIN) && out_free);
  assign full       = count_r == CW'(ENTRIES);
  assign walk_done  = !more_r || (k_r == KW'(MAX_RESULTS)) || (freed_r >= need_r);
  assign usage_sum  = {1'b0, usage_r} + {5'b0, size_r};
  assign avail      = (limit_r > usage_r) ? (limit_r - usage_r) : '0;

  // slot holding the current walk rank; ranks of valid slots are distinct
  always_comb begin
    walk_s = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((CW'(i) < count_r) && (rank_r[i] == r_r)) begin
        walk_s = walk_s | RW'(i);
      end
    end
  end

  assign ram_we = (state_r == S_UPD) && (act_r == ACT_REG) && !hit_r && !full;
  assign ram_wa = count_r[RW-1:0];
  assign ram_wd = {id_r, size_r};
  assign ram_re = ((state_r == S_SCAN) && scan_issue) ||
                  ((state_r == S_WRD) && !walk_done && !pinned_r[walk_s]);
  assign ram_ra = (state_r == S_SCAN) ? cnt_r[RW-1:0] : walk_s;

  lpet_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_slot_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .q   (ram_q)
  );

  assign in_ch.ready      = state_r == S_IDLE;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.victim_id = out_vid_r;
  assign out_ch.free_bytes = out_free_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.action)
            ACT_QUERY: state_nxt = S_FIN;
            ACT_LIST:  state_nxt = S_WRD;
            default:   state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: if (!scan_issue && !cmp_v_r) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_FIN;
      S_WRD: begin
        if (walk_done) begin
          state_nxt = S_FIN;
        end else if (!pinned_r[walk_s]) begin
          state_nxt = S_WDT;
        end
      end
      S_WDT:  if ((k_r == '0) || out_free) state_nxt = S_WRD;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      usage_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        pinned_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            act_r   <= in_ch.action;
            id_r    <= in_ch.object_id;
            size_r  <= in_ch.object_size;
            pin_r   <= in_ch.pin_value;
            need_r  <= in_ch.needed_bytes;
            cnt_r   <= '0;
            cmp_v_r <= 1'b0;
            hit_r   <= 1'b0;
            k_r     <= '0;
            freed_r <= '0;
            r_r     <= RW'(count_r - CW'(1));
            more_r  <= count_r != '0;
            st_r    <= ST_OK;
            vid_r   <= '0;
          end
        end
        S_SCAN: begin
          cmp_v_r   <= scan_issue;
          cmp_idx_r <= cnt_r[RW-1:0];
          if (scan_issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (cmp_v_r && (q_id == id_r)) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_idx_r;
          end
        end
        S_UPD: begin
          vid_r <= id_r;
          if (act_r == ACT_REG) begin
            if (hit_r) begin
              // touch: younger slots age by one
              for (int i = 0; i < ENTRIES; i++) begin
                if ((CW'(i) < count_r) && (RW'(i) != hit_idx_r) &&
                    (rank_r[i] < rank_r[hit_idx_r])) begin
                  rank_r[i] <= rank_r[i] + RW'(1);
                end
              end
              rank_r[hit_idx_r] <= '0;
              st_r <= ST_UPDATED;
            end else if (full) begin
              st_r <= ST_FULL;
            end else begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (CW'(i) < count_r) begin
                  rank_r[i] <= rank_r[i] + RW'(1);
                end
              end
              rank_r[count_r[RW-1:0]]   <= '0;
              pinned_r[count_r[RW-1:0]] <= 1'b0;
              count_r <= count_r + CW'(1);
              usage_r <= usage_sum[44] ? BYTES_MAX : usage_sum[43:0];
              st_r    <= ST_OK;
            end
          end else begin
            if (hit_r) begin
              pinned_r[hit_idx_r] <= pin_r;
              st_r <= ST_UPDATED;
            end else begin
              st_r <= ST_NONE;
            end
          end
        end
        S_WRD: begin
          if (walk_done) begin
            st_r <= (k_r == '0) ? ST_NONE : ST_OK;
            if (k_r == '0) begin
              vid_r <= '0;
            end
          end else begin
            if (r_r == '0) begin
              more_r <= 1'b0;
            end else begin
              r_r <= r_r - RW'(1);
            end
          end
        end
        S_WDT: begin
          if ((k_r == '0) || out_free) begin
            // previous candidate goes out, known now not to be the final one
            if (k_r != '0) begin
              out_status_r <= ST_OK;
              out_vid_r    <= vid_r;
              out_free_r   <= avail;
              out_last_r   <= 1'b0;
            end
            vid_r   <= q_id;
            k_r     <= k_r + KW'(1);
            freed_r <= freed_r + {4'b0, q_size};
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_status_r <= st_r;
            out_vid_r    <= vid_r;
            out_free_r   <= avail;
            out_last_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("slot count exceeds table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)))
    else $error("slot count moved by more than one");

  a_usage_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> usage_r >= $past(usage_r))
    else $error("usage decreased");

  a_list_cap: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= KW'(MAX_RESULTS))
    else $error("candidate count beyond result cap");

endmodule

### rtl/lpet_ram.sv
module lpet_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule
